// ===== hdl/xiss_pkg.sv =====
// ----------------------------------------------------------------------------
// xiss_pkg
// Shared types and constants of the x86 subset instruction stepper.
// ----------------------------------------------------------------------------
package xiss_pkg;

  localparam int unsigned STEP_W = 22;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_LENGTH = 2'd0,
    CFG_DATA_BASE   = 2'd1,
    CFG_DATA_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CAUSE_RUNNING  = 3'd0,
    CAUSE_END_CODE = 3'd1,
    CAUSE_EXIT     = 3'd2,
    CAUSE_RET      = 3'd3,
    CAUSE_TRUNC    = 3'd4,
    CAUSE_STEPS    = 3'd5
  } cause_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  localparam logic [7:0] OP_MOV_IMM = 8'hB8;
  localparam logic [7:0] OP_INT     = 8'hCD;
  localparam logic [7:0] VEC_SYS    = 8'h80;
  localparam logic [7:0] OP_LEA     = 8'h8D;
  localparam logic [7:0] OP_ESC     = 8'h0F;
  localparam logic [7:0] OP2_MOVZX  = 8'hB6;
  localparam logic [7:0] OP2_MOVSX  = 8'hBE;
  localparam logic [7:0] OP_RET     = 8'hC3;
  localparam logic [7:0] OP_MOV_ST  = 8'h89;
  localparam logic [7:0] OP_MOV_LD  = 8'h8B;
  localparam logic [7:0] OP_XOR_ST  = 8'h31;
  localparam logic [7:0] OP_XOR_LD  = 8'h33;
  localparam logic [7:0] OP_ADD     = 8'h01;
  localparam logic [7:0] OP_SUB     = 8'h29;
  localparam logic [7:0] OP_MUL     = 8'hF7;
  localparam logic [7:0] OP_DIV     = 8'hF6;
  localparam logic [7:0] MRM_MUL    = 8'hE0;
  localparam logic [7:0] MRM_DIV    = 8'hF0;

  localparam logic [31:0] SYS_WRITE = 32'd1;
  localparam logic [31:0] SYS_EXIT  = 32'd2;
  localparam logic [31:0] SYS_READ  = 32'd3;

  localparam logic [STEP_W-1:0] BUDGET_MIN  = STEP_W'(2048);
  localparam logic [STEP_W-1:0] BUDGET_BASE = STEP_W'(1024);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic take;
    logic rd_a;
    logic rd_b;
    logic exec;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_go;
    logic div_last;
  } dp_sts_t;

endpackage

// ===== hdl/xiss_ctrl.sv =====
// ----------------------------------------------------------------------------
// xiss_ctrl
// Sequencer: operand reads, execute, divide loop and output register handoff.
// ----------------------------------------------------------------------------
module xiss_ctrl
  import xiss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd_o.rd_a = 1'b1;
        state_d    = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_b = 1'b1;
        state_d    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.div_go ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;

  a_take_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_RD_A)
    else $error("accepted beat did not start operand read");

  a_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !sts_i.div_go) |=> state_q == ST_DONE)
    else $error("divide loop entered without a divide");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_DONE)
    else $error("output valid raised outside completion");

endmodule

// ===== hdl/xiss_dp.sv =====
// ----------------------------------------------------------------------------
// xiss_dp
// Datapath: register file, program counter, step budget, decode, execute,
// 32x32 multiplier, iterative divider and output register.
// ----------------------------------------------------------------------------
module xiss_dp
  import xiss_pkg::*;
#(
  parameter int unsigned CODE_MAX_BYTES = 65536,
  parameter int unsigned WRITE_MAX_LEN  = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [87:0]          in_data_i,
  output logic [103:0]         out_data_o,
  input  ctrl_cmd_t            cmd_i,
  output dp_sts_t              sts_o
);

  logic [16:0] clen_q;
  logic [31:0] dbase_q, dlen_q;
  logic [63:0] ins_q;
  logic [7:0]  mem_q;
  logic [15:0] line_q;
  logic [31:0] a_q, b_q;
  logic [31:0] r_q [8];
  logic [31:0] r_d [8];
  logic [16:0] pc_q;
  logic [STEP_W-1:0] step_q;
  logic        stop_q;
  logic [2:0]  cause_q;
  logic [1:0]  req_q;
  logic [31:0] addr_q;
  logic [15:0] cnt_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [4:0]  dcnt_q;
  logic [103:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clen_q  <= '0;
      dbase_q <= '0;
      dlen_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CODE_LENGTH: clen_q  <= cfg_data_i[16:0];
        CFG_DATA_BASE:   dbase_q <= cfg_data_i;
        CFG_DATA_LENGTH: dlen_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode
  logic [7:0]  op, m, b2;
  logic [1:0]  mod;
  logic [2:0]  rg, rm;
  logic [31:0] word1, word2, word3;
  logic [16:0] len;
  logic [17:0] pcx, lenx;
  logic        has1, movx;
  logic [2:0]  rd_a_addr;
  logic [STEP_W-1:0] budget, bud_raw;

  assign op    = ins_q[7:0];
  assign m     = ins_q[15:8];
  assign b2    = ins_q[23:16];
  assign mod   = m[7:6];
  assign rg    = m[5:3];
  assign rm    = m[2:0];
  assign word1 = ins_q[39:8];
  assign word2 = ins_q[47:16];
  assign word3 = ins_q[55:24];

  assign len  = ({15'd0, clen_q} > 32'(CODE_MAX_BYTES)) ? 17'(CODE_MAX_BYTES) : clen_q;
  assign pcx  = {1'b0, pc_q};
  assign lenx = {1'b0, len};
  assign has1 = (pcx + 18'd1) < lenx;
  assign movx = (op == OP_ESC) && ((m == OP2_MOVZX) || (m == OP2_MOVSX));
  assign rd_a_addr = movx ? {1'b0, b2[1:0]} : rm;

  assign bud_raw = {1'b0, len, 4'd0} + BUDGET_BASE;
  assign budget  = (bud_raw < BUDGET_MIN) ? BUDGET_MIN : bud_raw;

  function automatic logic in_data(input logic [31:0] a, input logic [31:0] base,
                                   input logic [31:0] dlen);
    logic [31:0] off;
    off = a - base;
    return (a >= base) && (off < dlen);
  endfunction

  // execute
  logic [3:0]  adv;
  logic [2:0]  cause;
  logic        run, w_en, mul_en, div_go;
  logic [2:0]  w_addr;
  logic [31:0] w_data;
  logic [1:0]  req;
  logic [31:0] addr;
  logic [15:0] cnt;
  logic [63:0] prod;
  logic [31:0] dm1, nsel, ea, v;
  logic [1:0]  mod2;
  logic [2:0]  rm2;

  assign prod = {32'd0, r_q[0]} * {32'd0, a_q};

  always_comb begin
    adv    = 4'd0;
    cause  = CAUSE_RUNNING;
    run    = 1'b0;
    w_en   = 1'b0;
    w_addr = rg;
    w_data = '0;
    mul_en = 1'b0;
    div_go = 1'b0;
    req    = REQ_NONE;
    addr   = '0;
    cnt    = '0;
    dm1    = r_q[2] - 32'd1;
    nsel   = ({16'd0, line_q} > dm1) ? dm1 : {16'd0, line_q};
    ea     = '0;
    v      = '0;
    mod2   = b2[7:6];
    rm2    = b2[2:0];
    if (!stop_q) begin
      if (pcx >= lenx) cause = CAUSE_END_CODE;
      else if (step_q >= budget) cause = CAUSE_STEPS;
      else begin
        run = 1'b1;
        if (op[7:3] == OP_MOV_IMM[7:3]) begin
          if ((pcx + 18'd4) < lenx) begin
            w_en = 1'b1; w_addr = op[2:0]; w_data = word1; adv = 4'd5;
          end else cause = CAUSE_TRUNC;
        end else if (op == OP_INT) begin
          if (!has1) cause = CAUSE_TRUNC;
          else begin
            adv = 4'd2;
            if (m == VEC_SYS) begin
              w_addr = 3'd0;
              w_data = '1;
              if (r_q[0] == SYS_WRITE) begin
                w_en = 1'b1;
                if (r_q[3] == 32'd1 && r_q[2] != 32'd0 &&
                    r_q[2] <= 32'(WRITE_MAX_LEN) && in_data(r_q[1], dbase_q, dlen_q)) begin
                  req = REQ_WRITE; addr = r_q[1]; cnt = r_q[2][15:0]; w_data = r_q[2];
                end
              end else if (r_q[0] == SYS_EXIT) begin
                cause = CAUSE_EXIT;
              end else if (r_q[0] == SYS_READ) begin
                w_en = 1'b1;
                if (r_q[3] == 32'd0 && r_q[1] != 32'd0 && r_q[2] != 32'd0 &&
                    !r_q[2][31] && in_data(r_q[1], dbase_q, dlen_q)) begin
                  req = REQ_READ; addr = r_q[1]; cnt = nsel[15:0]; w_data = nsel;
                end
              end else w_en = 1'b1;
            end
          end
        end else if (op == OP_LEA) begin
          if (has1) begin
            adv = 4'd2;
            if (mod == 2'd0 && rm == 3'd5) begin
              if ((pcx + 18'd6) <= lenx) begin ea = word2; adv = 4'd6; end
            end else if (mod == 2'd0 && rm == 3'd4) begin
              if ((pcx + 18'd3) <= lenx) begin
                adv = 4'd3;
                if (b2[2:0] == 3'd5 && (pcx + 18'd7) <= lenx) begin ea = word3; adv = 4'd7; end
              end
            end else if (mod == 2'd2) adv = 4'd6;
            else if (mod == 2'd1) adv = 4'd3;
            w_en = (ea != 32'd0); w_addr = rg; w_data = ea;
          end else adv = 4'd1;
        end else if (op == OP_ESC) begin
          if (!has1) adv = 4'd1;
          else if (movx) begin
            if ((pcx + 18'd2) < lenx) begin
              adv = 4'd3;
              if (mod2 == 2'd3) begin
                v = rm2[2] ? {24'd0, a_q[15:8]} : {24'd0, a_q[7:0]};
              end else if (mod2 == 2'd0 && rm2 == 3'd5 && (pcx + 18'd6) <= lenx) begin
                adv = 4'd7;
                v = in_data(word3, dbase_q, dlen_q) ? {24'd0, mem_q} : 32'd0;
              end
              w_en = 1'b1; w_addr = b2[5:3];
              w_data = (m == OP2_MOVSX && v[7]) ? (v | 32'hFFFFFF00) : v;
            end else adv = 4'd2;
          end else adv = 4'd2;
        end else if (op == OP_RET) begin
          cause = CAUSE_RET;
        end else if (op == OP_MOV_ST || op == OP_MOV_LD || op == OP_XOR_ST ||
                     op == OP_XOR_LD || op == OP_ADD || op == OP_SUB ||
                     op == OP_MUL || op == OP_DIV) begin
          if (!has1) adv = 4'd1;
          else begin
            adv = 4'd2;
            priority case (op)
              OP_MOV_ST: begin w_en = (mod == 2'd3); w_addr = rm; w_data = b_q; end
              OP_MOV_LD: begin w_en = (mod == 2'd3); w_addr = rg; w_data = a_q; end
              OP_XOR_ST: begin w_en = (mod == 2'd3); w_addr = rm; w_data = a_q ^ b_q; end
              OP_XOR_LD: begin w_en = (mod == 2'd3); w_addr = rg; w_data = a_q ^ b_q; end
              OP_ADD:    begin w_en = 1'b1; w_addr = rm; w_data = a_q + b_q; end
              OP_SUB:    begin w_en = 1'b1; w_addr = rm; w_data = a_q - b_q; end
              OP_MUL:    mul_en = ((m & 8'hF8) == MRM_MUL);
              default:   div_go = ((m & 8'hF8) == MRM_DIV) && (a_q != 32'd0);
            endcase
          end
        end else adv = 4'd1;
      end
    end
  end

  assign sts_o.div_go   = div_go;
  assign sts_o.div_last = (dcnt_q == 5'd31);

  // divider step
  logic [32:0] dsh, dtr;
  logic        dbit;
  logic [31:0] rem_n, quo_n;
  assign dsh   = {rem_q, quo_q[31]};
  assign dtr   = dsh - {1'b0, dvs_q};
  assign dbit  = !dtr[32];
  assign rem_n = dbit ? dtr[31:0] : dsh[31:0];
  assign quo_n = {quo_q[30:0], dbit};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      r_d[i] = r_q[i];
    end
    if (cmd_i.exec && run) begin
      if (w_en) r_d[w_addr] = w_data;
      if (mul_en) begin
        r_d[0] = prod[31:0];
        r_d[2] = prod[63:32];
      end
    end
    if (cmd_i.div_step && sts_o.div_last) begin
      r_d[0] = quo_n;
      r_d[2] = rem_n;
    end
  end

  logic [17:0] pc_sum;
  assign pc_sum = pcx + {14'd0, adv};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        r_q[i] <= '0;
      end
      pc_q    <= '0;
      step_q  <= '0;
      stop_q  <= 1'b0;
      cause_q <= CAUSE_RUNNING;
    end else begin
      for (int i = 0; i < 8; i++) begin
        r_q[i] <= r_d[i];
      end
      if (cmd_i.exec) begin
        if (run) step_q <= step_q + STEP_W'(1);
        if (cause != CAUSE_RUNNING) begin
          stop_q  <= 1'b1;
          cause_q <= cause;
        end else if (!stop_q) begin
          pc_q <= pc_sum[16:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ins_q  <= in_data_i[63:0];
      mem_q  <= in_data_i[71:64];
      line_q <= in_data_i[87:72];
    end
    if (cmd_i.rd_a) a_q <= r_q[rd_a_addr];
    if (cmd_i.rd_b) b_q <= r_q[rg];
    if (cmd_i.exec) begin
      req_q  <= req;
      addr_q <= addr;
      cnt_q  <= cnt;
      rem_q  <= '0;
      quo_q  <= r_q[0];
      dvs_q  <= a_q;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_n;
      quo_q  <= quo_n;
      dcnt_q <= dcnt_q + 5'd1;
    end
    if (cmd_i.load_out) begin
      out_q <= {1'b0, r_q[0], cnt_q, addr_q, req_q,
                (stop_q ? cause_q : CAUSE_RUNNING), stop_q, pc_q};
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/x86_subset_instruction_stepper.sv =====
// ----------------------------------------------------------------------------
// x86_subset_instruction_stepper
// Executes one instruction of a small 32-bit x86 subset per input beat.
// ----------------------------------------------------------------------------
// Each beat passes the accept, the two register file read steps, the execute
// step and the output load; a nonzero divide adds the divide loop after execute.
// A new beat is taken only after the output load, which waits for a free output.
// A finished result waits in the output register while the next beat starts.
// Reset clears registers, counter, step count, halt state and configuration.
module x86_subset_instruction_stepper
  import xiss_pkg::*;
#(
  parameter int unsigned CODE_MAX_BYTES = 65536,
  parameter int unsigned WRITE_MAX_LEN  = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // insn_bytes[63:0], mem_byte[71:64], line_len[87:72]
  input  logic [87:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // next_pc[16:0], halted[17], halt_cause[20:18], host_request[22:21],
  // host_address[54:23], host_count[70:55], accumulator[102:71]
  output logic [103:0]         m_axis_tdata
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  xiss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  xiss_dp #(
    .CODE_MAX_BYTES(CODE_MAX_BYTES),
    .WRITE_MAX_LEN (WRITE_MAX_LEN)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (s_axis_tdata),
    .out_data_o(m_axis_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule

// ===== bench/x86_subset_instruction_stepper_tb.sv =====
// ----------------------------------------------------------------------------
// x86_subset_instruction_stepper_tb
// Runs instruction streams through the stepper: a directed opening, then
// random syscall sequences, ALU ops, lea/movzx/movsx forms and noise, across
// several data section and code length settings, ending in a halt. Every
// output beat is checked against a cycle-free model of the stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86_subset_instruction_stepper_tb;
  import xiss_pkg::*;

  localparam int unsigned CODE_MAX = 65536;
  localparam int unsigned WR_MAX   = 512;

  typedef struct packed {
    logic [31:0] acc;
    logic [15:0] cnt;
    logic [31:0] addr;
    logic [1:0]  req;
    logic [2:0]  cause;
    logic        halted;
    logic [16:0] pc;
  } step_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [87:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [103:0]         m_axis_tdata;

  x86_subset_instruction_stepper i_dut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  logic [31:0] rf [8];
  logic [16:0] pc_q;
  int unsigned steps_q;
  bit          halted_q;
  logic [2:0]  cause_q;
  logic [16:0] code_len_q;
  logic [31:0] data_base_q, data_len_q;

  logic [87:0] insn_q [$];
  step_res_t   want_q [$];
  int          send_idle, recv_stall;
  int          errors;
  logic        hold_go = 1'b0;
  int          hold_left;

  function automatic logic [7:0] byte_of(logic [63:0] b, int unsigned i);
    return b[(i & 7) * 8 +: 8];
  endfunction

  function automatic logic [31:0] word_of(logic [63:0] b, int unsigned i);
    return {byte_of(b, i + 3), byte_of(b, i + 2), byte_of(b, i + 1), byte_of(b, i)};
  endfunction

  function automatic bit in_data(logic [31:0] a);
    return a >= data_base_q && (a - data_base_q) < data_len_q;
  endfunction

  function automatic int unsigned code_len_eff();
    return code_len_q < CODE_MAX ? code_len_q : CODE_MAX;
  endfunction

  task automatic exec_insn(input logic [63:0] b, input logic [7:0] mem,
                           input logic [15:0] line, output step_res_t res);
    int unsigned len, budget, pcw, stp;
    logic [7:0]  op, m, m2;
    logic [1:0]  md, md2;
    logic [2:0]  rg, rm, dst, rm2;
    logic [31:0] ea, v, s, n, d, addr;
    logic [63:0] p;
    logic [15:0] cnt;
    bit          has1;
    cause_e      cause;
    req_e        req;
    len = code_len_eff();
    budget = len * 16 + 1024;
    if (budget < 2048) budget = 2048;
    pcw = pc_q;
    cause = CAUSE_RUNNING;
    req = REQ_NONE;
    addr = '0;
    cnt = '0;
    if (!halted_q) begin
      if (pcw >= len) cause = CAUSE_END_CODE;
      else if (steps_q >= budget) cause = CAUSE_STEPS;
      else begin
        op = byte_of(b, 0);
        m = byte_of(b, 1);
        md = m[7:6];
        rg = m[5:3];
        rm = m[2:0];
        has1 = pcw + 1 < len;
        steps_q++;
        if (op >= OP_MOV_IMM && op <= OP_MOV_IMM + 8'd7) begin
          if (pcw + 4 < len) begin
            rf[op[2:0]] = word_of(b, 1);
            pcw += 5;
          end else cause = CAUSE_TRUNC;
        end else if (op == OP_INT) begin
          if (!has1) cause = CAUSE_TRUNC;
          else begin
            if (m == VEC_SYS) begin
              if (rf[0] == SYS_WRITE) begin
                if (rf[3] == 1 && rf[2] > 0 && rf[2] <= WR_MAX && in_data(rf[1])) begin
                  req = REQ_WRITE;
                  addr = rf[1];
                  cnt = rf[2][15:0];
                  rf[0] = rf[2];
                end else rf[0] = '1;
              end else if (rf[0] == SYS_EXIT) begin
                cause = CAUSE_EXIT;
              end else if (rf[0] == SYS_READ) begin
                if (rf[3] == 0 && rf[1] != 0 && rf[2] > 0 && rf[2] < 32'h8000_0000 &&
                    in_data(rf[1])) begin
                  n = line;
                  if (n > rf[2] - 1) n = rf[2] - 1;
                  req = REQ_READ;
                  addr = rf[1];
                  cnt = n[15:0];
                  rf[0] = n;
                end else rf[0] = '1;
              end else rf[0] = '1;
            end
            if (cause == CAUSE_RUNNING) pcw += 2;
          end
        end else if (op == OP_LEA) begin
          if (has1) begin
            ea = '0;
            stp = 2;
            if (md == 0 && rm == 5) begin
              if (pcw + 6 <= len) begin
                ea = word_of(b, 2);
                stp = 6;
              end
            end else if (md == 0 && rm == 4) begin
              if (pcw + 3 <= len) begin
                stp = 3;
                if (b[18:16] == 3'd5 && pcw + 7 <= len) begin
                  ea = word_of(b, 3);
                  stp = 7;
                end
              end
            end else if (md == 2) stp = 6;
            else if (md == 1) stp = 3;
            if (ea != 0) rf[rg] = ea;
            pcw += stp;
          end else pcw += 1;
        end else if (op == OP_ESC) begin
          if (!has1) pcw += 1;
          else if (m == OP2_MOVZX || m == OP2_MOVSX) begin
            if (pcw + 2 < len) begin
              m2 = byte_of(b, 2);
              md2 = m2[7:6];
              dst = m2[5:3];
              rm2 = m2[2:0];
              v = '0;
              stp = 3;
              if (md2 == 3) begin
                s = rf[rm2[1:0]];
                v = rm2 < 4 ? {24'h0, s[7:0]} : {24'h0, s[15:8]};
              end else if (md2 == 0 && rm2 == 5 && pcw + 6 <= len) begin
                stp = 7;
                v = in_data(word_of(b, 3)) ? {24'h0, mem} : '0;
              end
              if (m == OP2_MOVSX && v[7]) rf[dst] = v | 32'hFFFF_FF00;
              else rf[dst] = v;
              pcw += stp;
            end else pcw += 2;
          end else pcw += 2;
        end else if (op == OP_RET) begin
          cause = CAUSE_RET;
        end else if (op == OP_MOV_ST || op == OP_MOV_LD || op == OP_XOR_ST ||
                     op == OP_XOR_LD || op == OP_ADD || op == OP_SUB ||
                     op == OP_MUL || op == OP_DIV) begin
          if (!has1) pcw += 1;
          else begin
            if (op == OP_MOV_ST) begin
              if (md == 3) rf[rm] = rf[rg];
            end else if (op == OP_MOV_LD) begin
              if (md == 3) rf[rg] = rf[rm];
            end else if (op == OP_XOR_ST) begin
              if (md == 3) rf[rm] = rf[rm] ^ rf[rg];
            end else if (op == OP_XOR_LD) begin
              if (md == 3) rf[rg] = rf[rg] ^ rf[rm];
            end else if (op == OP_ADD) rf[rm] = rf[rm] + rf[rg];
            else if (op == OP_SUB) rf[rm] = rf[rm] - rf[rg];
            else if (op == OP_MUL) begin
              if ((m & 8'hF8) == MRM_MUL) begin
                p = 64'(rf[0]) * 64'(rf[rm]);
                rf[0] = p[31:0];
                rf[2] = p[63:32];
              end
            end else begin
              if ((m & 8'hF8) == MRM_DIV && rf[rm] != 0) begin
                d = rf[rm];
                v = rf[0];
                rf[0] = v / d;
                rf[2] = v % d;
              end
            end
            pcw += 2;
          end
        end else pcw += 1;
      end
      if (cause != CAUSE_RUNNING) begin
        halted_q = 1'b1;
        cause_q = cause;
      end
      pc_q = pcw[16:0];
    end
    res.pc = pc_q;
    res.halted = halted_q;
    res.cause = halted_q ? cause_q : CAUSE_RUNNING;
    res.req = req;
    res.addr = addr;
    res.cnt = cnt;
    res.acc = rf[0];
  endtask

  task automatic push_insn(input logic [63:0] b, input logic [7:0] mem, input logic [15:0] line);
    step_res_t res;
    int unsigned len;
    len = code_len_eff();
    for (int i = 0; i < 8; i++) if (pc_q + i >= len) b[i*8 +: 8] = 8'h00;
    insn_q.push_back({line, mem, b});
    exec_insn(b, mem, line, res);
    want_q.push_back(res);
  endtask

  task automatic push_plain(input logic [63:0] b);
    push_insn(b, 8'($urandom), 16'($urandom));
  endtask

  task automatic mov_imm(input int r, input logic [31:0] val);
    push_plain({24'h0, val, OP_MOV_IMM + 8'(r)});
  endtask

  function automatic logic [31:0] data_addr();
    if (data_len_q == 0) return data_base_q;
    return data_base_q + ($urandom % data_len_q);
  endfunction

  task automatic syscall_seq(input bit allow_halt);
    logic [31:0] eax, ebx, ecx, edx;
    int          r;
    r = $urandom_range(99);
    eax = r < 35 ? SYS_WRITE : r < 70 ? SYS_READ : 32'($urandom_range(5));
    if (eax == SYS_EXIT && !allow_halt) eax = 32'd4;
    r = $urandom_range(99);
    ebx = r < 80 ? (eax == SYS_WRITE ? 32'd1 : 32'd0) : r < 90 ? 32'($urandom_range(3)) : $urandom;
    r = $urandom_range(99);
    ecx = r < 75 ? data_addr() : r < 85 ? 32'd0 : $urandom;
    r = $urandom_range(99);
    case ($urandom_range(6))
      0: edx = 32'd0;
      1: edx = WR_MAX;
      2: edx = WR_MAX + 1;
      3: edx = 32'h7FFF_FFFF;
      4: edx = 32'h8000_0000;
      5: edx = $urandom;
      default: edx = 32'd1;
    endcase
    if (r < 70) edx = $urandom_range(1, WR_MAX);
    mov_imm(0, eax);
    mov_imm(3, ebx);
    mov_imm(1, ecx);
    mov_imm(2, edx);
    r = $urandom_range(3);
    push_insn({48'h0, VEC_SYS, OP_INT}, 8'($urandom),
              r == 0 ? 16'hFFFF : r == 1 ? 16'h0000 : 16'($urandom));
  endtask

  task automatic random_insn(input bit allow_halt);
    logic [63:0] b;
    logic [7:0]  ops [8];
    int          r;
    ops = '{OP_MOV_ST, OP_MOV_LD, OP_XOR_ST, OP_XOR_LD, OP_ADD, OP_SUB, OP_ADD, OP_SUB};
    b = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 20) begin
      syscall_seq(allow_halt);
      return;
    end else if (r < 34) begin
      b[7:0] = OP_MOV_IMM + 8'($urandom_range(7));
      if ($urandom_range(3) == 0) b[39:8] = $urandom_range(1) ? 32'hFFFF_FFFF : data_addr();
    end else if (r < 43) begin
      b[7:0] = OP_LEA;
      if ($urandom_range(1)) b[15:8] = {2'b00, b[13:11], 3'd5};
      if ($urandom_range(2) == 0) b[23:16] = {b[23:19], 3'd5};
    end else if (r < 55) begin
      b[7:0] = OP_ESC;
      if ($urandom_range(9) != 0) b[15:8] = $urandom_range(1) ? OP2_MOVZX : OP2_MOVSX;
      if ($urandom_range(1)) begin
        b[23:16] = {2'b00, b[21:19], 3'd5};
        if ($urandom_range(3) != 0) b[55:24] = data_addr();
      end
    end else if (r < 75) begin
      b[7:0] = ops[$urandom_range(7)];
      if ($urandom_range(3) != 0) b[15:14] = 2'b11;
    end else if (r < 82) begin
      b[7:0] = OP_MUL;
      if ($urandom_range(4) != 0) b[15:8] = MRM_MUL | 8'($urandom_range(7));
    end else if (r < 88) begin
      b[7:0] = OP_DIV;
      if ($urandom_range(4) != 0) b[15:8] = MRM_DIV | 8'($urandom_range(7));
    end else if (r < 93) begin
      b[7:0] = OP_INT;
    end else if (allow_halt && r < 95) begin
      b[7:0] = OP_RET;
    end
    if (!allow_halt) begin
      if (b[7:0] == OP_RET) b[7:0] = 8'h90;
      if (b[7:0] == OP_INT && b[15:8] == VEC_SYS && rf[0] == SYS_EXIT) b[15:8] = 8'h21;
    end
    push_plain(b);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CODE_LENGTH: code_len_q = val[16:0];
      CFG_DATA_BASE:   data_base_q = val;
      default:         data_len_q = val;
    endcase
  endtask

  task automatic drain();
    while (insn_q.size() != 0 || want_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count, input int idle, input int stall);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < count; i++) random_insn(1'b0);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) void'(insn_q.pop_front());
      if (insn_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= insn_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_go) hold_left <= 300;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    step_res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[102:0];
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: %h", m_axis_tdata);
        end else begin
          want = want_q.pop_front();
          if (got !== want || m_axis_tdata[103] !== 1'b0) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch pc %h/%h halt %b/%b cause %0d/%0d req %0d/%0d ",
                        "addr %h/%h cnt %h/%h acc %h/%h (exp/act)"},
                       want.pc, got.pc, want.halted, got.halted, want.cause, got.cause,
                       want.req, got.req, want.addr, got.addr, want.cnt, got.cnt,
                       want.acc, got.acc);
          end
        end
      end
      m_axis_tready <= hold_left == 0 && $urandom_range(99) >= recv_stall;
    end
  end

  initial begin
    int k;
    errors = 0;
    hold_left = 0;
    send_idle = 0;
    recv_stall = 0;
    foreach (rf[i]) rf[i] = '0;
    pc_q = '0;
    steps_q = 0;
    halted_q = 0;
    cause_q = CAUSE_RUNNING;
    code_len_q = '0;
    data_base_q = '0;
    data_len_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_cfg(CFG_CODE_LENGTH, CODE_MAX);
    write_cfg(CFG_DATA_BASE, 32'h0000_1000);
    write_cfg(CFG_DATA_LENGTH, 32'h0000_0800);

    mov_imm(0, 32'hFFFF_FFFF);
    mov_imm(3, 32'd3);
    push_plain(64'h0000_0000_0000_E3F7);            // mul ebx
    mov_imm(1, 32'd0);
    push_plain(64'h0000_0000_0000_F1F6);            // div ecx, zero divisor
    mov_imm(1, 32'd7);
    push_plain(64'h0000_0000_0000_F1F6);            // div ecx
    push_plain(64'h0000_0000_0000_C801);            // add eax, ecx
    push_plain(64'h0000_0000_0000_D129);            // sub ecx, edx
    push_plain(64'h0000_0000_0000_C389);
    push_plain(64'h0000_0000_0000_0A8B);            // mod 0: no effect
    push_plain(64'h0000_0000_0000_DB31);
    push_plain(64'h0000_0000_0000_C733);
    push_plain(64'h0000_1234_5678_358D);            // lea esi, [disp32]
    push_plain(64'h0012_3456_7825_3C8D);            // lea edi, SIB base 5
    push_plain(64'h0000_0000_0000_058D);            // lea eax, [0] keeps eax
    push_plain(64'h0000_0000_00AA_458D);            // mod 1
    push_plain(64'h0000_0000_0000_858D);            // mod 2
    push_insn(64'h0000_0010_0005_B60F, 8'hFF, 16'h0);  // movzx eax, [data]
    push_insn(64'h0000_0010_0415_BE0F, 8'h80, 16'h0);  // movsx edx, [data]
    push_insn(64'h0000_2000_0005_BE0F, 8'h80, 16'h0);  // outside data
    push_plain(64'h0000_0000_00E4_BE0F);            // movsx esp, ah
    push_plain(64'h0000_0000_0000_A20F);
    mov_imm(0, SYS_WRITE); mov_imm(3, 32'd1); mov_imm(1, 32'h1010); mov_imm(2, 32'd16);
    push_plain(64'h0000_0000_0000_80CD);
    mov_imm(0, SYS_READ); mov_imm(3, 32'd0); mov_imm(1, 32'h1020); mov_imm(2, 32'd8);
    push_insn(64'h0000_0000_0000_80CD, 8'h00, 16'hFFFF);
    mov_imm(0, 32'd5);
    push_plain(64'h0000_0000_0000_80CD);            // unknown syscall
    push_plain(64'h0000_0000_0000_21CD);            // other vector
    push_plain(64'hFFFF_FFFF_FFFF_FF90);
    drain();

    random_phase(160, 67, 0);
    drain();
    write_cfg(CFG_DATA_BASE, 32'h0);
    write_cfg(CFG_DATA_LENGTH, 32'hFFFF_FFFF);
    write_cfg(CFG_CODE_LENGTH, 32'h1_FFFF);
    random_phase(160, 0, 67);
    drain();
    write_cfg(CFG_DATA_BASE, 32'hFFFF_FF00);
    write_cfg(CFG_DATA_LENGTH, 32'h100);
    random_phase(160, 0, 0);
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    drain();
    send_idle = 14;
    recv_stall = 14;
    for (int i = 0; i < 160; i++) random_insn(1'b0);
    drain();
    write_cfg(CFG_DATA_BASE, $urandom);
    write_cfg(CFG_DATA_LENGTH, 32'h0);
    write_cfg(CFG_CODE_LENGTH, CODE_MAX - 1);
    random_phase(160, 0, 0);
    drain();
    write_cfg(CFG_DATA_BASE, 32'h2000);
    write_cfg(CFG_DATA_LENGTH, 32'h1000);
    random_phase(140, 0, 67);
    drain();

    k = $urandom_range(0, 7);
    write_cfg(CFG_CODE_LENGTH, k == 0 ? 32'h0 : 32'(pc_q) + k);
    send_idle = 14;
    recv_stall = 14;
    while (!halted_q) random_insn(1'b1);
    for (int i = 0; i < 5; i++) random_insn(1'b1);
    drain();

    if (errors == 0 && want_q.size() == 0) begin
      $display("** x86_subset_instruction_stepper: PASSED **");
    end else begin
      $display("** x86_subset_instruction_stepper: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** x86_subset_instruction_stepper: FAILED **");
    $finish;
  end

endmodule
